FILE: hdl/prs_pkg.sv
// Shared types, constants and codes for the edge-centric PageRank engine.
package prs_pkg;

  // Vertex store geometry.
  localparam int unsigned MAX_VERTICES = 65536;
  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W = AW + 1;

  // Field widths.
  localparam int unsigned RANK_W = 56;
  localparam int unsigned DEG_W = 32;
  localparam int unsigned DAMP_W = 16;
  localparam int unsigned VID_W = 16;
  localparam int unsigned VCNT_W = 17;

  localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};
  localparam logic [DEG_W-1:0] DEG_MAX = {DEG_W{1'b1}};

  // Register reset values.
  localparam logic [VCNT_W-1:0] VCNT_RST = 17'd65536;
  localparam logic [RANK_W-1:0] BASE_RST = 56'd603979776;
  localparam logic [DAMP_W-1:0] DAMP_RST = 16'd55705;
  localparam logic [RANK_W-1:0] TOL_RST = 56'd281475;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_VCOUNT = 2'd0,
    REG_BASE   = 2'd1,
    REG_DAMP   = 2'd2,
    REG_TOL    = 2'd3
  } reg_idx_t;

  // Input actions.
  typedef enum logic [2:0] {
    ACT_CLEAR   = 3'd0,
    ACT_COUNT   = 3'd1,
    ACT_SCATTER = 3'd2,
    ACT_APPLY   = 3'd3,
    ACT_FINISH  = 3'd4,
    ACT_READ    = 3'd5
  } act_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_UPDATE  = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_RANK    = 2'd2
  } kind_t;

  // One vertex entry.
  typedef struct packed {
    logic              mark;
    logic [DEG_W-1:0]  degree;
    logic [RANK_W-1:0] acc;
    logic [RANK_W-1:0] rank;
  } vword_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CNT,
    ST_SC_DST,
    ST_SC_SRC,
    ST_DIV,
    ST_APP,
    ST_FIN_RD,
    ST_FIN_MUL,
    ST_FIN_WB,
    ST_RDR,
    ST_EMIT
  } state_t;

endpackage

FILE: hdl/prs_mem.sv
// Vertex store: one write port and one registered read port.
module prs_mem (
  input  logic                 clk,
  input  logic                 we,
  input  logic [prs_pkg::AW-1:0] waddr,
  input  prs_pkg::vword_t      wdata,
  input  logic                 re,
  input  logic [prs_pkg::AW-1:0] raddr,
  output prs_pkg::vword_t      rdata
);
  import prs_pkg::*;

  vword_t mem [MAX_VERTICES];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/prs_div.sv
// Restoring divider for rank by out-degree, one quotient bit per cycle.
module prs_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [prs_pkg::RANK_W-1:0] dividend,
  input  logic [prs_pkg::DEG_W-1:0]  divisor,
  output logic                       done,
  output logic [prs_pkg::RANK_W-1:0] quotient
);
  import prs_pkg::*;

  localparam int unsigned STEP_W = $clog2(RANK_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DEG_W:0]    rem_r, rem_nxt;
  logic [RANK_W-1:0] quo_r, quo_nxt;
  logic [DEG_W-1:0]  dsr_r, dsr_nxt;
  logic [DEG_W:0]    trial;

  // One shift-and-subtract step per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r[DEG_W-1:0], quo_r[RANK_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = trial - {1'b0, dsr_r};
        quo_nxt = {quo_r[RANK_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[RANK_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(RANK_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: hdl/pagerank_edge_scatter_gather_top.sv
// Top level: sequencer around the vertex store, divider and finish datapath.
// Count and apply read a vertex and write it back; read fetches a rank; scatter reads both vertices,
// then divides unless the degree is zero. Finish walks the vertices in use, writing back unconverged ones.
// Rate is set by the read-modify-write on the vertex store and the divider; one item at a time.
// After reset and after each clear action, a sweep over all 65536 entries fills the store
// while in_tready stays low; configuration writes are taken during it.
module pagerank_edge_scatter_gather_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [87:0]  in_tdata,   // src_vertex[15:0], dst_vertex[31:16], contribution[87:32]
  input  logic [2:0]   in_tuser,   // action[2:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // vertex_id[15:0], value[71:16], unconverged[88:72],
                                   // all_converged[89], zero fill[95:90]
  output logic [1:0]   out_tuser,  // kind[1:0]
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_addr,
  input  logic [55:0]  cfg_wdata
);
  import prs_pkg::*;

  // Configuration registers.
  logic [VCNT_W-1:0] vcount_r;
  logic [RANK_W-1:0] base_r;
  logic [DAMP_W-1:0] damp_r;
  logic [RANK_W-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCNT_RST;
      base_r   <= BASE_RST;
      damp_r   <= DAMP_RST;
      tol_r    <= TOL_RST;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_VCOUNT: vcount_r <= cfg_wdata[VCNT_W-1:0];
        REG_BASE:   base_r   <= cfg_wdata;
        REG_DAMP:   damp_r   <= cfg_wdata[DAMP_W-1:0];
        REG_TOL:    tol_r    <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // Vertices in use.
  logic [VCNT_W-1:0] n_use;
  assign n_use = (vcount_r > VCNT_W'(MAX_VERTICES)) ? VCNT_W'(MAX_VERTICES) : vcount_r;

  // Input fields.
  logic [VID_W-1:0]  in_src, in_dst;
  logic [RANK_W-1:0] in_con;
  act_t              in_act;
  assign in_src = in_tdata[15:0];
  assign in_dst = in_tdata[31:16];
  assign in_con = in_tdata[87:32];
  assign in_act = act_t'(in_tuser);

  // Sequencer and datapath registers.
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RANK_W-1:0] clr_base_r, clr_base_nxt;
  logic [VID_W-1:0]  src_r, src_nxt, dst_r, dst_nxt;
  logic [RANK_W-1:0] con_r, con_nxt;
  logic [VCNT_W-1:0] unc_r, unc_nxt;
  logic [RANK_W-1:0] prod_hi_r, prod_hi_nxt;
  logic [15:0]       prod_lo_r, prod_lo_nxt;
  vword_t            word_r, word_nxt;
  kind_t             res_kind_r, res_kind_nxt;
  logic [VID_W-1:0]  res_id_r, res_id_nxt;
  logic [RANK_W-1:0] res_val_r, res_val_nxt;
  logic [VCNT_W-1:0] res_unc_r, res_unc_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic [VID_W-1:0]  out_id_r, out_id_nxt;
  logic [RANK_W-1:0] out_val_r, out_val_nxt;
  logic [VCNT_W-1:0] out_unc_r, out_unc_nxt;
  logic              out_all_r, out_all_nxt;

  // Memory and divider hookups.
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  vword_t        mem_wdata, mem_rdata;
  logic          div_start, div_done;
  logic [RANK_W-1:0] div_quo;

  prs_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  prs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mem_rdata.rank),
    .divisor  (mem_rdata.degree),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Range checks and walk position.
  logic src_ok, dst_ok, in_acc, out_free, fin_last, clr_last;
  assign src_ok   = {1'b0, in_src} < n_use;
  assign dst_ok   = {1'b0, in_dst} < n_use;
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign fin_last = (cnt_r + 1'b1) == n_use;
  assign clr_last = cnt_r == CNT_W'(MAX_VERTICES - 1);

  // Finish arithmetic: scaled sum, fresh rank and change against tolerance.
  logic [RANK_W:0]   scaled_w, fresh_w;
  logic [RANK_W-1:0] scaled, fresh, diff;
  logic              frozen;
  assign scaled_w = {1'b0, prod_hi_r} + {{(RANK_W-15){1'b0}}, prod_lo_r};
  assign scaled   = scaled_w[RANK_W] ? RANK_MAX : scaled_w[RANK_W-1:0];
  assign fresh_w  = {1'b0, base_r} + {1'b0, scaled};
  assign fresh    = fresh_w[RANK_W] ? RANK_MAX : fresh_w[RANK_W-1:0];
  assign diff     = (word_r.rank > fresh) ? word_r.rank - fresh : fresh - word_r.rank;
  assign frozen   = diff < tol_r;

  // Saturating accumulate for apply.
  logic [RANK_W:0] acc_sum;
  assign acc_sum = {1'b0, mem_rdata.acc} + {1'b0, con_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:   if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_act)
            ACT_CLEAR:   state_nxt = ST_CLEAR;
            ACT_COUNT:   state_nxt = src_ok ? ST_CNT : ST_IDLE;
            ACT_SCATTER: state_nxt = (src_ok && dst_ok) ? ST_SC_DST : ST_IDLE;
            ACT_APPLY:   state_nxt = dst_ok ? ST_APP : ST_IDLE;
            ACT_FINISH:  state_nxt = (n_use == '0) ? ST_EMIT : ST_FIN_RD;
            ACT_READ:    state_nxt = dst_ok ? ST_RDR : ST_EMIT;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CNT:     state_nxt = ST_IDLE;
      ST_SC_DST:  state_nxt = mem_rdata.mark ? ST_IDLE : ST_SC_SRC;
      ST_SC_SRC:  state_nxt = (mem_rdata.degree == '0) ? ST_EMIT : ST_DIV;
      ST_DIV:     if (div_done) state_nxt = ST_EMIT;
      ST_APP:     state_nxt = ST_IDLE;
      ST_FIN_RD:  state_nxt = ST_FIN_MUL;
      ST_FIN_MUL: begin
        if (!mem_rdata.mark) state_nxt = ST_FIN_WB;
        else if (fin_last)   state_nxt = ST_EMIT;
        else                 state_nxt = ST_FIN_RD;
      end
      ST_FIN_WB:  state_nxt = fin_last ? ST_EMIT : ST_FIN_RD;
      ST_RDR:     state_nxt = ST_EMIT;
      ST_EMIT:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory control and register updates.
  always_comb begin
    in_tready    = state_r == ST_IDLE;
    mem_we       = 1'b0;
    mem_waddr    = cnt_r[AW-1:0];
    mem_wdata    = mem_rdata;
    mem_re       = 1'b0;
    mem_raddr    = cnt_r[AW-1:0];
    div_start    = 1'b0;
    cnt_nxt      = cnt_r;
    clr_base_nxt = clr_base_r;
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    con_nxt      = con_r;
    unc_nxt      = unc_r;
    prod_hi_nxt  = prod_hi_r;
    prod_lo_nxt  = prod_lo_r;
    word_nxt     = word_r;
    res_kind_nxt = res_kind_r;
    res_id_nxt   = res_id_r;
    res_val_nxt  = res_val_r;
    res_unc_nxt  = res_unc_r;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_wdata    = '{mark: 1'b0, degree: '0, acc: '0, rank: clr_base_r};
        cnt_nxt      = clr_last ? '0 : cnt_r + 1'b1;
      end
      ST_IDLE: begin
        if (in_acc) begin
          src_nxt = in_src;
          dst_nxt = in_dst;
          con_nxt = in_con;
          unique case (in_act)
            ACT_CLEAR: begin
              cnt_nxt      = '0;
              clr_base_nxt = base_r;
            end
            ACT_COUNT: begin
              mem_re    = 1'b1;
              mem_raddr = in_src[AW-1:0];
            end
            ACT_SCATTER, ACT_APPLY, ACT_READ: begin
              mem_re    = 1'b1;
              mem_raddr = in_dst[AW-1:0];
              if (in_act == ACT_READ) begin
                res_kind_nxt = KIND_RANK;
                res_id_nxt   = in_dst;
                res_val_nxt  = '0;
                res_unc_nxt  = '0;
              end else begin
                res_kind_nxt = KIND_UPDATE;
                res_id_nxt   = in_dst;
                res_val_nxt  = '0;
                res_unc_nxt  = '0;
              end
            end
            ACT_FINISH: begin
              cnt_nxt      = '0;
              unc_nxt      = '0;
              res_kind_nxt = KIND_SUMMARY;
              res_id_nxt   = '0;
              res_val_nxt  = '0;
              res_unc_nxt  = '0;
            end
            default: ;
          endcase
        end
      end
      ST_CNT: begin
        mem_we    = 1'b1;
        mem_waddr = src_r[AW-1:0];
        if (mem_rdata.degree != DEG_MAX) begin
          mem_wdata.degree = mem_rdata.degree + 1'b1;
        end
      end
      ST_SC_DST: begin
        mem_re    = !mem_rdata.mark;
        mem_raddr = src_r[AW-1:0];
      end
      ST_SC_SRC: begin
        div_start   = mem_rdata.degree != '0;
        res_val_nxt = '0;
      end
      ST_DIV: begin
        if (div_done) res_val_nxt = div_quo;
      end
      ST_APP: begin
        mem_waddr = dst_r[AW-1:0];
        mem_we    = !mem_rdata.mark;
        mem_wdata.acc = acc_sum[RANK_W] ? RANK_MAX : acc_sum[RANK_W-1:0];
      end
      ST_FIN_RD: begin
        mem_re    = 1'b1;
        mem_raddr = cnt_r[AW-1:0];
      end
      ST_FIN_MUL: begin
        word_nxt    = mem_rdata;
        prod_hi_nxt = RANK_W'(mem_rdata.acc[RANK_W-1:16] * damp_r);
        prod_lo_nxt = 16'((32'(mem_rdata.acc[15:0]) * 32'(damp_r)) >> 16);
        if (mem_rdata.mark) begin
          if (fin_last) res_unc_nxt = unc_r;
          else cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FIN_WB: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r[AW-1:0];
        mem_wdata = word_r;
        mem_wdata.acc = '0;
        if (frozen) begin
          mem_wdata.mark = 1'b1;
        end else begin
          mem_wdata.rank = fresh;
          unc_nxt        = unc_r + 1'b1;
        end
        if (fin_last) res_unc_nxt = frozen ? unc_r : unc_r + 1'b1;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_RDR: begin
        res_val_nxt = mem_rdata.rank;
      end
      ST_EMIT: ;
      default: ;
    endcase
  end

  // Output register loads a result when it is free or its transfer completes.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_val_nxt   = out_val_r;
    out_unc_nxt   = out_unc_r;
    out_all_nxt   = out_all_r;
    if (state_r == ST_EMIT && out_free) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = res_kind_r;
      out_id_nxt    = res_id_r;
      out_val_nxt   = res_val_r;
      out_unc_nxt   = res_unc_r;
      out_all_nxt   = (res_kind_r == KIND_SUMMARY) && (res_unc_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      clr_base_r  <= BASE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_base_r  <= clr_base_nxt;
      out_valid_r <= out_valid_nxt;
    end
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    con_r      <= con_nxt;
    unc_r      <= unc_nxt;
    prod_hi_r  <= prod_hi_nxt;
    prod_lo_r  <= prod_lo_nxt;
    word_r     <= word_nxt;
    res_kind_r <= res_kind_nxt;
    res_id_r   <= res_id_nxt;
    res_val_r  <= res_val_nxt;
    res_unc_r  <= res_unc_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_val_r  <= out_val_nxt;
    out_unc_r  <= out_unc_nxt;
    out_all_r  <= out_all_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {6'b0, out_all_r, out_unc_r, out_val_r, out_id_r};

endmodule

FILE: sim/rank_checker.sv
// Result checker for the PageRank engine: tracks vertex state, predicts and compares results.
`timescale 1ns / 1ps

module rank_checker
  import prs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [87:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [55:0] cfg_wdata,
  output int          errors,
  output int          pending
);

  typedef struct {
    kind_t             kind;
    logic [VID_W-1:0]  vid;
    logic [RANK_W-1:0] value;
    logic [VCNT_W-1:0] unc;
    logic              all_conv;
  } rank_result_t;

  // Shadow copy of the engine's registers and vertex store.
  logic [VCNT_W-1:0] vcount_q;
  logic [RANK_W-1:0] base_q;
  logic [DAMP_W-1:0] damp_q;
  logic [RANK_W-1:0] tol_q;
  logic [RANK_W-1:0] rank_mem [MAX_VERTICES];
  logic [RANK_W-1:0] acc_mem [MAX_VERTICES];
  logic [DEG_W-1:0]  deg_mem [MAX_VERTICES];
  logic              mark_mem [MAX_VERTICES];

  rank_result_t expected_results [$];

  assign pending = expected_results.size();

  function automatic logic [RANK_W-1:0] sat_sum(logic [RANK_W-1:0] a, logic [RANK_W-1:0] b);
    logic [RANK_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[RANK_W] ? RANK_MAX : s[RANK_W-1:0];
  endfunction

  task automatic clear_store();
    for (int v = 0; v < MAX_VERTICES; v++) begin
      rank_mem[v] = base_q;
      acc_mem[v] = '0;
      deg_mem[v] = '0;
      mark_mem[v] = 1'b0;
    end
  endtask

  // Walk the vertices in use and return how many are still moving.
  function automatic logic [VCNT_W-1:0] finish_iteration(int n);
    logic [71:0]       prod;
    logic [RANK_W-1:0] fresh;
    logic [RANK_W-1:0] diff;
    logic [VCNT_W-1:0] moving;
    moving = '0;
    for (int v = 0; v < n; v++) begin
      if (!mark_mem[v]) begin
        prod = acc_mem[v] * damp_q;
        fresh = sat_sum(base_q, prod[71:16]);
        diff = rank_mem[v] > fresh ? rank_mem[v] - fresh : fresh - rank_mem[v];
        if (diff < tol_q) begin
          mark_mem[v] = 1'b1;
        end else begin
          rank_mem[v] = fresh;
          moving++;
        end
        acc_mem[v] = '0;
      end
    end
    return moving;
  endfunction

  // Apply one accepted input transfer and queue the result it should produce.
  task automatic predict_action(logic [2:0] act, logic [15:0] src, logic [15:0] dst,
                                logic [RANK_W-1:0] contrib);
    int n;
    rank_result_t r;
    n = vcount_q > MAX_VERTICES ? MAX_VERTICES : int'(vcount_q);
    r.kind = KIND_UPDATE;
    r.vid = '0;
    r.value = '0;
    r.unc = '0;
    r.all_conv = 1'b0;
    case (act)
      ACT_CLEAR: clear_store();
      ACT_COUNT: begin
        if (src < n && deg_mem[src] != DEG_MAX) deg_mem[src]++;
      end
      ACT_SCATTER: begin
        if (src < n && dst < n && !mark_mem[dst]) begin
          r.vid = dst;
          r.value = deg_mem[src] != 0 ? rank_mem[src] / deg_mem[src] : '0;
          expected_results.push_back(r);
        end
      end
      ACT_APPLY: begin
        if (dst < n && !mark_mem[dst]) acc_mem[dst] = sat_sum(acc_mem[dst], contrib);
      end
      ACT_FINISH: begin
        r.kind = KIND_SUMMARY;
        r.unc = finish_iteration(n);
        r.all_conv = (r.unc == 0);
        expected_results.push_back(r);
      end
      ACT_READ: begin
        r.kind = KIND_RANK;
        r.vid = dst;
        r.value = dst < n ? rank_mem[dst] : '0;
        expected_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t: result %s mismatch: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    vcount_q = VCNT_RST;
    base_q = BASE_RST;
    damp_q = DAMP_RST;
    tol_q = TOL_RST;
    clear_store();
  end

  // Observe all three ports at each rising edge.
  always @(posedge clk) begin
    rank_result_t want;
    if (rst_n) begin
      if (cfg_wr_en) begin
        case (reg_idx_t'(cfg_addr))
          REG_VCOUNT: vcount_q = cfg_wdata[VCNT_W-1:0];
          REG_BASE:   base_q = cfg_wdata;
          REG_DAMP:   damp_q = cfg_wdata[DAMP_W-1:0];
          REG_TOL:    tol_q = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transfer, kind %0d", $realtime, out_tuser);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_tuser != want.kind)
            report_mismatch("kind", 64'(out_tuser), 64'(want.kind));
          if (out_tdata[15:0] != want.vid)
            report_mismatch("vertex_id", 64'(out_tdata[15:0]), 64'(want.vid));
          if (out_tdata[71:16] != want.value)
            report_mismatch("value", 64'(out_tdata[71:16]), 64'(want.value));
          if (out_tdata[88:72] != want.unc)
            report_mismatch("unconverged", 64'(out_tdata[88:72]), 64'(want.unc));
          if (out_tdata[89] != want.all_conv)
            report_mismatch("all_converged", 64'(out_tdata[89]), 64'(want.all_conv));
          if (out_tdata[95:90] != '0) report_mismatch("fill", 64'(out_tdata[95:90]), '0);
        end
      end
      if (in_tvalid && in_tready)
        predict_action(in_tuser, in_tdata[15:0], in_tdata[31:16], in_tdata[87:32]);
    end
  end

endmodule

FILE: sim/tb.sv
// Testbench top for the PageRank engine: stimulus, flow control and the final verdict.
`timescale 1ns / 1ps

module tb;
  import prs_pkg::*;

  localparam logic [2:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [55:0] cfg_wdata = '0;

  int errors;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pagerank_edge_scatter_gather_top dut (.*);

  rank_checker chk (.*);

  // Run length guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Long receiver hold-off, counted here once requested.
  always @(posedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    out_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
  end

  // Offer one item and return at the edge where it transfers; valid stays high.
  task automatic send(logic [2:0] act, logic [15:0] src, logic [15:0] dst, logic [55:0] contrib);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {contrib, dst, src};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop offering, let every result arrive and the engine settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_regs(logic [16:0] vc, logic [55:0] base, logic [15:0] damp,
                            logic [55:0] tol);
    cfg_wr_en <= 1'b1;
    cfg_addr <= REG_VCOUNT;
    cfg_wdata <= 56'(vc);
    @(posedge clk);
    cfg_addr <= REG_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_addr <= REG_DAMP;
    cfg_wdata <= 56'(damp);
    @(posedge clk);
    cfg_addr <= REG_TOL;
    cfg_wdata <= tol;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_vertex(int n);
    if ($urandom_range(99) < 20) return 16'($urandom);
    return 16'($urandom_range(0, n + 1));
  endfunction

  function automatic logic [55:0] pick_contrib();
    case ($urandom_range(2))
      0: return 56'({$urandom, $urandom});
      1: return 56'($urandom) << 12;
      default: return 56'($urandom_range(0, 1 << 20));
    endcase
  endfunction

  // Random traffic; mostly edges and updates on a small graph, some finishes and reads.
  task automatic random_phase(int items, int n, int send_idle, int recv_stall, bit with_hold);
    int w;
    logic [2:0] act;
    idle_pct = send_idle;
    stall_pct = recv_stall;
    for (int i = 0; i < items; i++) begin
      if (with_hold && i == items / 3) hold_req <= 1'b1;
      w = $urandom_range(99);
      if (w < 20) act = ACT_COUNT;
      else if (w < 50) act = ACT_SCATTER;
      else if (w < 70) act = ACT_APPLY;
      else if (w < 80) act = ACT_FINISH;
      else if (w < 96) act = ACT_READ;
      else act = w[0] ? ACT_UNUSED_LO : ACT_UNUSED_HI;
      send(act, pick_vertex(n), pick_vertex(n), pick_contrib());
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);

    // Directed: full-size graph with reset registers, then small-graph corners.
    send(ACT_READ, 16'd0, 16'd0, '0);
    send(ACT_READ, 16'd0, 16'hFFFF, '0);
    send(ACT_COUNT, 16'hFFFF, 16'd0, '0);
    send(ACT_SCATTER, 16'hFFFF, 16'd0, '0);
    send(ACT_SCATTER, 16'd3, 16'hFFFF, '0);
    send(ACT_APPLY, 16'd0, 16'hFFFF, RANK_MAX);
    send(ACT_APPLY, 16'd0, 16'hFFFF, RANK_MAX);
    send(ACT_FINISH, 16'd0, 16'd0, '0);
    send(ACT_READ, 16'd0, 16'hFFFF, '0);
    send(ACT_SCATTER, 16'hFFFF, 16'd5, '0);
    send(ACT_APPLY, 16'd0, 16'd5, 56'd12345);
    send(ACT_UNUSED_LO, 16'hFFFF, 16'hFFFF, RANK_MAX);
    send(ACT_UNUSED_HI, 16'd0, 16'd0, '0);
    drain();
    write_regs(17'd3, RANK_MAX, 16'hFFFF, '0);
    send(ACT_CLEAR, 16'd0, 16'd0, '0);
    send(ACT_READ, 16'd0, 16'd2, '0);
    send(ACT_READ, 16'd0, 16'd3, '0);
    send(ACT_COUNT, 16'd0, 16'd0, '0);
    send(ACT_COUNT, 16'd0, 16'd0, '0);
    send(ACT_COUNT, 16'd3, 16'd0, '0);
    send(ACT_SCATTER, 16'd0, 16'd1, '0);
    send(ACT_SCATTER, 16'd1, 16'd3, '0);
    send(ACT_APPLY, 16'd0, 16'd1, RANK_MAX);
    send(ACT_FINISH, 16'd0, 16'd0, '0);
    send(ACT_READ, 16'd0, 16'd1, '0);
    drain();
    write_regs(17'd0, 56'd0, 16'd0, RANK_MAX);
    send(ACT_FINISH, 16'd0, 16'd0, '0);
    send(ACT_READ, 16'd0, 16'd0, '0);
    drain();

    // Random phases under different flow-control patterns and settings.
    write_regs(17'd8, 56'h10_0000_0000, 16'd55705, 56'h1_0000_0000);
    send(ACT_CLEAR, 16'd0, 16'd0, '0);
    random_phase(240, 8, 0, 0, 1'b1);
    write_regs(17'd16, 56'h3_0000_0000, 16'hFFFF, 56'h40_0000_0000);
    random_phase(240, 16, 75, 0, 1'b0);
    write_regs(17'd5, 56'({$urandom, $urandom}), 16'd0, 56'h100_0000);
    send(ACT_CLEAR, 16'd0, 16'd0, '0);
    random_phase(240, 5, 0, 75, 1'b0);
    write_regs(17'd12, 56'h8000_0000_0000, 16'($urandom), 56'h10_0000_0000);
    random_phase(240, 12, 18, 18, 1'b0);

    if (errors == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/prs_pkg.sv
hdl/prs_mem.sv
hdl/prs_div.sv
hdl/pagerank_edge_scatter_gather_top.sv
sim/rank_checker.sv
sim/tb.sv
